// ----- rtl/lidar_frame_checksum_averager_core_macros.svh -----
// assertion macros for the lidar frame checksum averager core
// used by the rtl modules that carry concurrent checks; depends on nothing
`ifndef LIDAR_FRAME_CHECKSUM_AVERAGER_CORE_MACROS_SVH
`define LIDAR_FRAME_CHECKSUM_AVERAGER_CORE_MACROS_SVH
`ifndef SYNTH
`define LFCA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lfca assertion failed");
`define LFCA_ASSERT_NEVER(name, clk, rst_n, cond) \
  `LFCA_ASSERT(name, clk, rst_n, !(cond))
`else
`define LFCA_ASSERT(name, clk, rst_n, prop)
`define LFCA_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ----- rtl/lfca_pkg.sv -----
// shared types and constants of the lidar frame checksum averager
// no dependencies; used by the datapath, controller and top level
package lfca_pkg;

  localparam int unsigned MaxFrames = 32;
  localparam int unsigned SumW      = 21;
  localparam int unsigned CntW      = 6;
  localparam int unsigned FrameLen  = 9;
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned StepW     = $clog2(DivSteps + 1);

  localparam logic [7:0] HdrByte    = 8'h59;
  localparam logic [7:0] HdrPairSum = 8'(2 * HdrByte);

  localparam logic [3:0] PosFirst   = 4'd2;
  localparam logic [3:0] PosDistLo  = 4'd2;
  localparam logic [3:0] PosDistHi  = 4'd3;
  localparam logic [3:0] PosStrLo   = 4'd4;
  localparam logic [3:0] PosStrHi   = 4'd5;
  localparam logic [3:0] PosChk     = 4'(FrameLen - 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FRAME = 2'd1,
    STATUS_ALL_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic take;      // byte accepted
    logic last;      // accepted byte closes the buffer
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/lfca_if.sv -----
// valid/ready channel interfaces for the byte input and the result output
// depends on nothing; the status field is a plain two-bit vector
interface lfca_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface lfca_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mean_distance;
  logic [15:0] mean_strength;
  logic [5:0]  good_frames;
  logic [5:0]  bad_frames;
  logic [1:0]  status;

  modport source (output valid, output mean_distance, output mean_strength,
                  output good_frames, output bad_frames, output status, input ready);
  modport sink   (input valid, input mean_distance, input mean_strength,
                  input good_frames, input bad_frames, input status, output ready);
endinterface

// ----- rtl/lfca_datapath.sv -----
// frame parser, checksum/accumulate logic, shared restoring divider and result register
// depends on lfca_pkg; driven by lfca_ctrl through cmd_t / sts_t
module lfca_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfca_pkg::cmd_t      cmd_i,
  output lfca_pkg::sts_t      sts_o,
  input  logic [7:0]          rx_byte_i,
  output logic [15:0]         mean_distance_o,
  output logic [15:0]         mean_strength_o,
  output logic [5:0]          good_frames_o,
  output logic [5:0]          bad_frames_o,
  output logic [1:0]          status_o
);

  localparam int unsigned SumW = lfca_pkg::SumW;
  localparam int unsigned CntW = lfca_pkg::CntW;
  localparam int unsigned StepW = lfca_pkg::StepW;

  // parser and accumulator state
  logic            synced_q, synced_d;
  logic            prev_hdr_q, prev_hdr_d;
  logic [3:0]      pos_q, pos_d;
  logic [7:0]      chk_q, chk_d;
  logic [15:0]     dist_q, dist_d;
  logic [15:0]     str_q, str_d;
  logic [SumW-1:0] dsum_q, dsum_d;
  logic [SumW-1:0] ssum_q, ssum_d;
  logic [CntW-1:0] good_q, good_d;
  logic [CntW-1:0] bad_q, bad_d;

  // divider and pending result
  logic [SumW-1:0]  qd_q, qs_q;
  logic [CntW-1:0]  rd_q, rs_q;
  logic [CntW-1:0]  dvs_q;
  logic [CntW-1:0]  pend_bad_q;
  logic [1:0]       pend_status_q;
  logic [StepW-1:0] step_q;

  // output register
  logic [15:0]     res_dist_q, res_str_q;
  logic [CntW-1:0] res_good_q, res_bad_q;
  logic [1:0]      res_status_q;

  logic            under_limit;
  logic [SumW:0]   dsum_add, ssum_add;
  logic [CntW:0]   rd_sh, rs_sh;
  logic            ge_d, ge_s;
  lfca_pkg::status_e status_nx;

  assign under_limit = (8'(good_q) + 8'(bad_q)) < 8'(lfca_pkg::MaxFrames);
  assign dsum_add = {1'b0, dsum_q} + (SumW+1)'(dist_q);
  assign ssum_add = {1'b0, ssum_q} + (SumW+1)'(str_q);

  always_comb begin
    synced_d   = synced_q;
    prev_hdr_d = prev_hdr_q;
    pos_d      = pos_q;
    chk_d      = chk_q;
    dist_d     = dist_q;
    str_d      = str_q;
    dsum_d     = dsum_q;
    ssum_d     = ssum_q;
    good_d     = good_q;
    bad_d      = bad_q;
    if (!synced_q) begin
      if (prev_hdr_q && rx_byte_i == lfca_pkg::HdrByte) begin
        synced_d = 1'b1;
        pos_d    = lfca_pkg::PosFirst;
        chk_d    = lfca_pkg::HdrPairSum;
        dist_d   = '0;
        str_d    = '0;
      end
      prev_hdr_d = (rx_byte_i == lfca_pkg::HdrByte);
    end else if (pos_q < lfca_pkg::PosChk) begin
      chk_d = chk_q + rx_byte_i;
      if (pos_q == lfca_pkg::PosDistLo) dist_d[7:0]  = rx_byte_i;
      if (pos_q == lfca_pkg::PosDistHi) dist_d[15:8] = rx_byte_i;
      if (pos_q == lfca_pkg::PosStrLo)  str_d[7:0]   = rx_byte_i;
      if (pos_q == lfca_pkg::PosStrHi)  str_d[15:8]  = rx_byte_i;
      pos_d = pos_q + 4'd1;
    end else begin
      // checksum byte; frames past the limit are dropped uncounted
      if (under_limit) begin
        if (chk_q == rx_byte_i) begin
          dsum_d = dsum_add[SumW] ? '1 : dsum_add[SumW-1:0];
          ssum_d = ssum_add[SumW] ? '1 : ssum_add[SumW-1:0];
          if (good_q != '1) good_d = good_q + CntW'(1);
        end else begin
          if (bad_q != '1) bad_d = bad_q + CntW'(1);
        end
      end
      pos_d  = '0;
      chk_d  = '0;
      dist_d = '0;
      str_d  = '0;
    end
  end

  always_comb begin
    if (!synced_d || (good_d == '0 && bad_d == '0)) begin
      status_nx = lfca_pkg::STATUS_NO_FRAME;
    end else if (good_d == '0) begin
      status_nx = lfca_pkg::STATUS_ALL_BAD;
    end else begin
      status_nx = lfca_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q   <= 1'b0;
      prev_hdr_q <= 1'b0;
      pos_q      <= '0;
      chk_q      <= '0;
      dist_q     <= '0;
      str_q      <= '0;
      dsum_q     <= '0;
      ssum_q     <= '0;
      good_q     <= '0;
      bad_q      <= '0;
    end else if (cmd_i.last) begin
      // buffer closed: start over for the next one
      synced_q   <= 1'b0;
      prev_hdr_q <= 1'b0;
      pos_q      <= '0;
      chk_q      <= '0;
      dist_q     <= '0;
      str_q      <= '0;
      dsum_q     <= '0;
      ssum_q     <= '0;
      good_q     <= '0;
      bad_q      <= '0;
    end else if (cmd_i.take) begin
      synced_q   <= synced_d;
      prev_hdr_q <= prev_hdr_d;
      pos_q      <= pos_d;
      chk_q      <= chk_d;
      dist_q     <= dist_d;
      str_q      <= str_d;
      dsum_q     <= dsum_d;
      ssum_q     <= ssum_d;
      good_q     <= good_d;
      bad_q      <= bad_d;
    end
  end

  // restoring division, one quotient bit per cycle for both sums
  assign rd_sh = {rd_q, qd_q[SumW-1]};
  assign rs_sh = {rs_q, qs_q[SumW-1]};
  assign ge_d  = rd_sh >= {1'b0, dvs_q};
  assign ge_s  = rs_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(lfca_pkg::DivSteps);
    end else if (cmd_i.last) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.last) begin
      qd_q          <= dsum_d;
      qs_q          <= ssum_d;
      rd_q          <= '0;
      rs_q          <= '0;
      dvs_q         <= good_d;
      pend_bad_q    <= bad_d;
      pend_status_q <= status_nx;
    end else if (cmd_i.div_step) begin
      qd_q <= {qd_q[SumW-2:0], ge_d};
      qs_q <= {qs_q[SumW-2:0], ge_s};
      rd_q <= ge_d ? CntW'(rd_sh - {1'b0, dvs_q}) : rd_sh[CntW-1:0];
      rs_q <= ge_s ? CntW'(rs_sh - {1'b0, dvs_q}) : rs_sh[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      // no good frame: divisor was zero, report zero means
      res_dist_q   <= (dvs_q == '0) ? 16'd0 : qd_q[15:0];
      res_str_q    <= (dvs_q == '0) ? 16'd0 : qs_q[15:0];
      res_good_q   <= dvs_q;
      res_bad_q    <= pend_bad_q;
      res_status_q <= pend_status_q;
    end
  end

  assign sts_o.div_done = (step_q == StepW'(lfca_pkg::DivSteps));

  assign mean_distance_o = res_dist_q;
  assign mean_strength_o = res_str_q;
  assign good_frames_o   = res_good_q;
  assign bad_frames_o    = res_bad_q;
  assign status_o        = res_status_q;

endmodule

// ----- rtl/lfca_ctrl.sv -----
// controller: byte intake, divide sequencing and result register handshake
// depends on lfca_pkg and the assertion macros header
`include "lidar_frame_checksum_averager_core_macros.svh"
module lfca_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_eob_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lfca_pkg::cmd_t cmd_o,
  input  lfca_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_RUN);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o.take      = in_fire;
    cmd_o.last      = in_fire && in_eob_i;
    cmd_o.div_step  = 1'b0;
    cmd_o.out_load  = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (cmd_o.last) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          // result register free (or emptying this cycle)
          cmd_o.out_load = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LFCA_ASSERT(a_load_after_div, clk_i, rst_ni, cmd_o.out_load |-> sts_i.div_done)
  `LFCA_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load |-> (!out_valid_q || out_ready_i))
  `LFCA_ASSERT(a_last_enters_div, clk_i, rst_ni, cmd_o.last |=> (state_q == ST_DIV))
  `LFCA_ASSERT_NEVER(a_step_after_done, clk_i, rst_ni, cmd_o.div_step && sts_i.div_done)

endmodule

// ----- rtl/lidar_frame_checksum_averager_core.sv -----
// channel    dir  payload                                                    accepted when
// in_i       in   rx_byte[7:0], end_of_buffer                                valid && ready
// out_o      out  mean_distance, mean_strength, good_frames, bad_frames,
//                 status                                                     valid && ready
// one byte per cycle while a buffer streams in; the byte with end_of_buffer
// is followed by the steps of the shared bit-serial divider and the result load,
// during which in_i.ready is low
// the result sits in an output register until taken; a new buffer streams in
// meanwhile, and its divide waits after its last step if the old result is still there
// rst_ni is asynchronous and clears parser, counters, fsm and output valid
module lidar_frame_checksum_averager_core (
  input logic              clk_i,
  input logic              rst_ni,
  lfca_in_if.sink          in_i,
  lfca_out_if.source       out_o
);

  lfca_pkg::cmd_t cmd;
  lfca_pkg::sts_t sts;

  lfca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_eob_i    (in_i.end_of_buffer),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lfca_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (in_i.rx_byte),
    .mean_distance_o (out_o.mean_distance),
    .mean_strength_o (out_o.mean_strength),
    .good_frames_o   (out_o.good_frames),
    .bad_frames_o    (out_o.bad_frames),
    .status_o        (out_o.status)
  );

endmodule
